// ----- src/egcd_pkg.sv -----
// ----------------------------------------------------------------------------
// egcd_pkg: shared widths and control types for the extended GCD engine
// Operand and coefficient widths, and the step command to the arithmetic unit.
// ----------------------------------------------------------------------------
package egcd_pkg;

    localparam int DATA_WIDTH = 31;
    localparam int COEF_WIDTH = DATA_WIDTH + 1;
    localparam int CNT_WIDTH  = $clog2(COEF_WIDTH + 1);

    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [COEF_WIDTH-1:0] coef_t;
    typedef logic [CNT_WIDTH-1:0]  cnt_t;

    // control from sequencer to the datapath
    typedef struct packed {
        logic load;       // load operands, clear coefficients
        logic div_start;  // clear remainder, begin a division
        logic div_bit;    // one restoring division step
        logic mul_start;  // latch quotient for coefficient update
        logic mul_bit;    // one shift-subtract step on coefficients
        logic mul_done;   // rotate pairs: prev <= cur, cur <= t - q*x; dividend <= divisor, divisor <= remainder
    } ctrl_t;

    // status back to the sequencer
    typedef struct packed {
        logic rem_zero;
        logic n_zero;
    } stat_t;

endpackage

// ----- src/egcd_datapath.sv -----
// ----------------------------------------------------------------------------
// egcd_datapath: bit-serial divider and coefficient update
// Restoring division one quotient bit per cycle, then t - q*x by one quotient
// bit per cycle for both coefficient pairs.
// ----------------------------------------------------------------------------
module egcd_datapath
    import egcd_pkg::*;
(
    input  logic  clk,
    input  ctrl_t ctrl,
    input  data_t value_m,
    input  data_t value_n,
    output stat_t stat,
    output data_t divisor,
    output coef_t coef_a,
    output coef_t coef_b
);

    data_t dvd_reg, dvs_reg, quo_reg, rem_reg;
    data_t mq_reg;
    coef_t ap_reg, ac_reg, bp_reg, bc_reg;
    coef_t ax_reg, bx_reg;     // shifted multiplicand
    coef_t aacc_reg, bacc_reg; // running t - q*x

    // shifted partial remainder needs DATA_WIDTH+1 bits: one spare bit
    // above it for the borrow
    logic [DATA_WIDTH+1:0] trial;
    data_t                 rem_sh;

    assign rem_sh = {rem_reg[DATA_WIDTH-2:0], quo_reg[DATA_WIDTH-1]};
    assign trial  = {1'b0, rem_reg, quo_reg[DATA_WIDTH-1]} - {2'b00, dvs_reg};

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            dvd_reg <= value_m;
            dvs_reg <= value_n;
            ap_reg  <= coef_t'(1);
            ac_reg  <= '0;
            bp_reg  <= '0;
            bc_reg  <= coef_t'(1);
        end
        if (ctrl.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= dvd_reg;
        end
        else if (ctrl.div_bit)
        begin
            // quo_reg shifts dividend bits out the top, quotient bits in
            if (!trial[DATA_WIDTH+1])
            begin
                rem_reg <= trial[DATA_WIDTH-1:0];
                quo_reg <= {quo_reg[DATA_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[DATA_WIDTH-2:0], 1'b0};
            end
        end
        if (ctrl.mul_start)
        begin
            mq_reg   <= quo_reg;
            ax_reg   <= ac_reg;
            bx_reg   <= bc_reg;
            aacc_reg <= ap_reg;
            bacc_reg <= bp_reg;
        end
        else if (ctrl.mul_bit)
        begin
            if (mq_reg[0])
            begin
                aacc_reg <= aacc_reg - ax_reg;
                bacc_reg <= bacc_reg - bx_reg;
            end
            mq_reg <= mq_reg >> 1;
            ax_reg <= ax_reg << 1;
            bx_reg <= bx_reg << 1;
        end
        if (ctrl.mul_done)
        begin
            ap_reg  <= ac_reg;
            ac_reg  <= aacc_reg;
            bp_reg  <= bc_reg;
            bc_reg  <= bacc_reg;
            dvd_reg <= dvs_reg;
            dvs_reg <= rem_reg;
        end
    end

    assign stat.rem_zero = (rem_reg == '0);
    assign stat.n_zero   = (dvs_reg == '0);
    assign divisor = stat.n_zero ? dvd_reg : dvs_reg;
    assign coef_a  = stat.n_zero ? coef_t'(1) : ac_reg;
    assign coef_b  = stat.n_zero ? coef_t'(0) : bc_reg;

endmodule

// ----- src/egcd_seq.sv -----
// ----------------------------------------------------------------------------
// egcd_seq: step sequencer for the extended GCD engine
// Walks load, check, divide, test, multiply and rotate phases with a shared bit counter.
// ----------------------------------------------------------------------------
module egcd_seq
    import egcd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output ctrl_t ctrl,
    output logic  busy,
    output logic  done
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_TEST  = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_ROT   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] state_reg, state_next;
    cnt_t       cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ctrl       = '0;
        done       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.n_zero)
                    state_next = S_DONE;
                else
                begin
                    ctrl.div_start = 1'b1;
                    cnt_next       = cnt_t'(DATA_WIDTH - 1);
                    state_next     = S_DIV;
                end
            end
            S_DIV:
            begin
                ctrl.div_bit = 1'b1;
                cnt_next     = cnt_reg - cnt_t'(1);
                if (cnt_reg == '0)
                    state_next = S_TEST;
            end
            S_TEST:
            begin
                if (stat.rem_zero)
                    state_next = S_DONE;
                else
                begin
                    ctrl.mul_start = 1'b1;
                    cnt_next       = cnt_t'(DATA_WIDTH - 1);
                    state_next     = S_MUL;
                end
            end
            S_MUL:
            begin
                ctrl.mul_bit = 1'b1;
                cnt_next     = cnt_reg - cnt_t'(1);
                if (cnt_reg == '0)
                    state_next = S_ROT;
            end
            S_ROT:
            begin
                ctrl.mul_done = 1'b1;
                state_next    = S_CHECK;
            end
            S_DONE:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ----- src/extended_gcd_top.sv -----
// ----------------------------------------------------------------------------
// extended_gcd_top: extended Euclid, gcd plus Bezout coefficients
// The run grows with the number k of divisions (k up to about 45 at 31 bits);
//   one item at a time, next start accepted in the cycle after the result
//   beat.
// Each division and each coefficient update runs one bit per cycle.
// Result beat: valid high for one cycle; the receiver cannot stall.
// Reset: asynchronous active low, returns the sequencer to idle.
// ----------------------------------------------------------------------------
module extended_gcd_top
    import egcd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  data_t value_m,
    input  data_t value_n,
    output logic  valid,
    output data_t divisor,
    output coef_t coef_a,
    output coef_t coef_b
);

    ctrl_t ctrl;
    stat_t stat;

    // sequencer: division and multiply phases, one bit per cycle
    egcd_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy),
        .done  (valid)
    );

    // datapath: operands, remainder, both coefficient pairs
    egcd_datapath u_dp (
        .clk     (clk),
        .ctrl    (ctrl),
        .value_m (value_m),
        .value_n (value_n),
        .stat    (stat),
        .divisor (divisor),
        .coef_a  (coef_a),
        .coef_b  (coef_b)
    );

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for extended_gcd_top
// Drives operand pairs through the start/busy handshake and checks the gcd
// and the two Bezout coefficients against an in-bench Euclid predictor.
// ----------------------------------------------------------------------------
module tb;
    import egcd_pkg::*;

    // Euclid predictor plus a queue of pending answers
    class bezout_board;
        data_t exp_gcd[$];
        coef_t exp_a[$];
        coef_t exp_b[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        // accepted operand pair: work out gcd and coefficients
        function void note_operands(data_t m, data_t n);
            logic [63:0] dividend, dvsr, quo, rem, tmp;
            logic [63:0] ap, ac, bp, bc;
            if (n == '0)
            begin
                exp_gcd.push_back(m);
                exp_a.push_back(coef_t'(1));
                exp_b.push_back('0);
                return;
            end
            ap = 64'd1; ac = 64'd0; bp = 64'd0; bc = 64'd1;
            dividend = 64'(m);
            dvsr = 64'(n);
            forever
            begin
                quo = dividend / dvsr;
                rem = dividend % dvsr;
                if (rem == 64'd0)
                    break;
                dividend = dvsr;
                dvsr = rem;
                tmp = ap; ap = ac; ac = tmp - quo * ac;
                tmp = bp; bp = bc; bc = tmp - quo * bc;
            end
            exp_gcd.push_back(data_t'(dvsr));
            exp_a.push_back(coef_t'(ac));
            exp_b.push_back(coef_t'(bc));
        endfunction

        // result beat: compare with the oldest pending answer
        function void check_result(data_t g, coef_t a, coef_t b);
            data_t eg;
            coef_t ea, eb;
            if (exp_gcd.size() == 0)
            begin
                $display("%0t unexpected result: gcd %0d a %0d b %0d",
                         $time, g, $signed(a), $signed(b));
                errors++;
                return;
            end
            eg = exp_gcd.pop_front();
            ea = exp_a.pop_front();
            eb = exp_b.pop_front();
            if (g !== eg)
            begin
                $display("%0t divisor: expected %0d actual %0d", $time, eg, g);
                errors++;
            end
            if (a !== ea)
            begin
                $display("%0t coef_a: expected %0d actual %0d",
                         $time, $signed(ea), $signed(a));
                errors++;
            end
            if (b !== eb)
            begin
                $display("%0t coef_b: expected %0d actual %0d",
                         $time, $signed(eb), $signed(b));
                errors++;
            end
        endfunction
    endclass

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    data_t value_m;
    data_t value_n;
    logic  valid;
    data_t divisor;
    coef_t coef_a;
    coef_t coef_b;

    bezout_board board;
    int idle_pct;   // chance in a hundred that the sender holds off a cycle

    extended_gcd_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .value_m (value_m),
        .value_n (value_n),
        .valid   (valid),
        .divisor (divisor),
        .coef_a  (coef_a),
        .coef_b  (coef_b)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // results cannot be held off, so every strobe is simply checked
    always @(posedge clk)
    begin
        if (rst_n && valid === 1'b1)
            board.check_result(divisor, coef_a, coef_b);
    end

    // one beat: random idle gap, then start held until busy is seen low
    task automatic send_pair(data_t m, data_t n);
        while ($urandom_range(99, 0) < idle_pct)
        begin
            start   <= 1'b0;
            value_m <= data_t'($urandom);
            value_n <= data_t'($urandom);
            @(posedge clk);
        end
        start   <= 1'b1;
        value_m <= m;
        value_n <= n;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        // accepted at this edge
        board.note_operands(m, n);
    endtask

    // operand with a random size, mostly small to keep the run short
    function automatic data_t rand_operand();
        int bits;
        data_t v;
        bits = $urandom_range(DATA_WIDTH, 1);
        v = data_t'($urandom) >> (DATA_WIDTH - bits);
        if (v == '0)
            v = data_t'(1);
        return v;
    endfunction

    // about one pair in four shares a common factor of up to 4000, else random sizes
    task automatic send_random(int count);
        data_t g, m, n;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(3, 0) == 0)
            begin
                g = data_t'($urandom_range(4000, 1));
                m = data_t'(g * $urandom_range(500000, 1));
                n = data_t'(g * $urandom_range(500000, 1));
            end
            else
            begin
                m = rand_operand();
                n = rand_operand();
            end
            send_pair(m, n);
        end
    endtask

    initial
    begin
        data_t top;
        int wait_cycles;
        board    = new();
        idle_pct = 0;
        rst_n    = 1'b0;
        start    = 1'b0;
        value_m  = '0;
        value_n  = '0;
        top      = '1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: range extremes, equal and coprime operands, divisibility
        send_pair(data_t'(1), data_t'(1));
        send_pair(top, top);
        send_pair(top, data_t'(1));
        send_pair(data_t'(1), top);
        send_pair(top, top - data_t'(1));
        send_pair(top - data_t'(1), top);
        send_pair(data_t'(12), data_t'(18));
        send_pair(data_t'(18), data_t'(12));
        send_pair(data_t'(7), data_t'(21));
        send_pair(data_t'(21), data_t'(7));
        send_pair(data_t'(1836311903), data_t'(1134903170)); // Fibonacci: deepest
        send_pair(data_t'(1134903170), data_t'(1836311903));
        send_pair(data_t'(1073741824), data_t'(536870912));
        send_pair(data_t'(1431655765), data_t'(715827882));
        send_pair(data_t'(2), data_t'(3));

        // random phases: no idling, sender idle often, a mixed rate, then no idling again
        idle_pct = 0;  send_random(100);
        idle_pct = 58; send_random(100);
        idle_pct = 31; send_random(100);
        idle_pct = 0;  send_random(100);
        start <= 1'b0;

        // drain: one item at a time, so the last answer comes within one latency
        wait_cycles = 0;
        while (board.exp_gcd.size() != 0 && wait_cycles < 10000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (50) @(posedge clk);
        if (board.errors == 0 && board.exp_gcd.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog: room for ~420 items at the worst-case run time, four times over
    initial
    begin
        #(8 * 3000 * 420 * 4);
        $display("DONE: errors detected");
        $finish;
    end
endmodule

// ----- filelist.f -----
src/egcd_pkg.sv
src/egcd_datapath.sv
src/egcd_seq.sv
src/extended_gcd_top.sv
bench/tb.sv
